/* hw/rtl/mrfc_pkg.sv */
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// frame checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

    // Longest frame counted before the too-long status is raised
    localparam int unsigned LEN_W     = 9;
    localparam logic [LEN_W-1:0] MAX_FRAME = LEN_W'(256);

    // Minimum frame: address, function and two CRC bytes
    localparam logic [LEN_W-1:0] MIN_FRAME = LEN_W'(4);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Header byte positions within the frame
    localparam logic [LEN_W-1:0] POS_ADDRESS  = LEN_W'(0);
    localparam logic [LEN_W-1:0] POS_FUNCTION = LEN_W'(1);
    localparam logic [LEN_W-1:0] POS_REG_HI   = LEN_W'(2);
    localparam logic [LEN_W-1:0] POS_REG_LO   = LEN_W'(3);
    localparam logic [LEN_W-1:0] POS_CNT_HI   = LEN_W'(4);
    localparam logic [LEN_W-1:0] POS_CNT_LO   = LEN_W'(5);

    localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INCOMPLETE  = 3'd1,
        ST_WRONG_SLAVE = 3'd2,
        ST_CRC         = 3'd3,
        ST_TOO_LONG    = 3'd4
    } status_t;

    // One received byte as held in the input register
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_word_t;

    // One frame result as held in the output register
    typedef struct packed {
        status_t          frame_status;
        logic [7:0]       frame_address;
        logic [7:0]       func_code;
        logic [15:0]      start_reg;
        logic [15:0]      register_count;
        logic [LEN_W-1:0] frame_length;
    } result_t;

    // Reflected CRC-16 update over one byte, least significant bit first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

/* hw/rtl/mrfc_in_stage.sv */
// ----------------------------------------------------------------------------
// mrfc_in_stage
// Input register for received bytes; releases a word when the frame core
// takes it and accepts the next word in the same cycle.
// ----------------------------------------------------------------------------
module mrfc_in_stage
    import mrfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_end_of_frame,
    input  logic       take,
    output logic       word_valid,
    output in_word_t   word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     load;

    // Accept while empty or while the held word is being taken
    assign s_ready = !valid_reg || take;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on acceptance
    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg.rx_byte      <= s_rx_byte;
            word_reg.end_of_frame <= s_end_of_frame;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

/* hw/rtl/mrfc_frame_core.sv */
// ----------------------------------------------------------------------------
// mrfc_frame_core
// Per-frame state: running CRC, two-byte tail window, header capture and
// byte count. Produces the frame result on the last byte of a frame.
// ----------------------------------------------------------------------------
module mrfc_frame_core
    import mrfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       word_valid,
    input  in_word_t   word,
    input  logic       out_free,
    output logic       take,
    output logic       result_valid,
    output result_t    result
);

    logic [7:0]       slave_addr_reg;
    logic [15:0]      crc_reg,      crc_next;
    logic [7:0]       tail0_reg,    tail0_next;
    logic [7:0]       tail1_reg,    tail1_next;
    logic [7:0]       hdr_addr_reg, hdr_addr_next;
    logic [7:0]       hdr_func_reg, hdr_func_next;
    logic [15:0]      hdr_reg_reg,  hdr_reg_next;
    logic [15:0]      hdr_cnt_reg,  hdr_cnt_next;
    logic [LEN_W-1:0] count_reg,    count_next;
    logic             ovf_reg,      ovf_next;

    logic [15:0]      crc_upd;
    logic [15:0]      rx_crc;
    logic             below_max;
    status_t          status;

    // Hold the own device address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
        end else if (cfg_wr_en) begin
            slave_addr_reg <= cfg_wr_data;
        end
    end

    // Advance the held word whenever the output register can take a result
    assign take         = word_valid && out_free;
    assign result_valid = take && word.end_of_frame;

    // Fold the byte leaving the tail window into the CRC
    assign crc_upd   = (count_reg >= LEN_W'(2)) ? crc16_byte(crc_reg, tail0_reg) : crc_reg;
    assign below_max = (count_reg < MAX_FRAME);
    assign rx_crc    = {word.rx_byte, tail1_reg};

    // Updated frame state with this byte included
    always_comb begin
        hdr_addr_next = hdr_addr_reg;
        hdr_func_next = hdr_func_reg;
        hdr_reg_next  = hdr_reg_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        unique case (count_reg)
            POS_ADDRESS:  hdr_addr_next       = word.rx_byte;
            POS_FUNCTION: hdr_func_next       = word.rx_byte;
            POS_REG_HI:   hdr_reg_next[15:8]  = word.rx_byte;
            POS_REG_LO:   hdr_reg_next[7:0]   = word.rx_byte;
            POS_CNT_HI:   hdr_cnt_next[15:8]  = word.rx_byte;
            POS_CNT_LO:   hdr_cnt_next[7:0]   = word.rx_byte;
            default: ;
        endcase
        crc_next   = crc_upd;
        tail0_next = tail1_reg;
        tail1_next = word.rx_byte;
        count_next = below_max ? count_reg + LEN_W'(1) : count_reg;
        ovf_next   = ovf_reg || !below_max;
    end

    // Check in order: too long, incomplete, wrong slave, CRC
    always_comb begin
        priority if (ovf_next) begin
            status = ST_TOO_LONG;
        end else if (count_next < MIN_FRAME) begin
            status = ST_INCOMPLETE;
        end else if (hdr_addr_next != slave_addr_reg) begin
            status = ST_WRONG_SLAVE;
        end else if (crc_next != rx_crc) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        result.frame_status   = status;
        result.frame_address  = hdr_addr_next;
        result.func_code      = hdr_func_next;
        result.start_reg      = hdr_reg_next;
        result.register_count = hdr_cnt_next;
        result.frame_length   = count_next;
    end

    // Update frame state; clear it after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || result_valid) begin
            crc_reg      <= CRC_INIT;
            tail0_reg    <= '0;
            tail1_reg    <= '0;
            hdr_addr_reg <= '0;
            hdr_func_reg <= '0;
            hdr_reg_reg  <= '0;
            hdr_cnt_reg  <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end else if (take) begin
            crc_reg      <= crc_next;
            tail0_reg    <= tail0_next;
            tail1_reg    <= tail1_next;
            hdr_addr_reg <= hdr_addr_next;
            hdr_func_reg <= hdr_func_next;
            hdr_reg_reg  <= hdr_reg_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
        end
    end

    // A frame end leaves the count, the overflow flag and the CRC cleared
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid |=> (count_reg == '0) && !ovf_reg && (crc_reg == CRC_INIT))
        else $error("frame state not cleared after end of frame");

    // Count saturates at the frame limit
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_FRAME)
        else $error("byte count beyond frame limit");

    // Overflow only once the count has saturated
    a_ovf_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == MAX_FRAME))
        else $error("overflow flagged below frame limit");

endmodule

/* hw/rtl/mrfc_out_stage.sv */
// ----------------------------------------------------------------------------
// mrfc_out_stage
// Result register; holds a frame result until the consumer takes it and
// reports when it can load a new one.
// ----------------------------------------------------------------------------
module mrfc_out_stage
    import mrfc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    out_free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t held
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Free when empty or when the held result leaves this cycle
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign held    = result_reg;

endmodule

/* hw/rtl/modbus_rtu_frame_checker.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker
// Checks received Modbus RTU frames byte by byte and reports one status word
// with the captured header at the end of each frame.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and answers each frame one result
// word, valid once its last byte has passed the input register and then the
// result register. The rate is set by the CRC-16 update, header capture and
// status checks done combinationally between those two registers; a held
// result stalls input only when the consumer does not take it.
module modbus_rtu_frame_checker
    import mrfc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  logic             s_end_of_frame,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_frame_status,
    output logic [7:0]       m_frame_address,
    output logic [7:0]       m_func_code,
    output logic [15:0]      m_start_reg,
    output logic [15:0]      m_register_count,
    output logic [LEN_W-1:0] m_frame_length
);

    in_word_t word;
    logic     word_valid;
    logic     take;
    logic     out_free;
    logic     result_valid;
    result_t  result;
    result_t  held;

    // Register incoming bytes
    mrfc_in_stage u_in (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_end_of_frame (s_end_of_frame),
        .take           (take),
        .word_valid     (word_valid),
        .word           (word)
    );

    // Track the frame and form the result
    mrfc_frame_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .word_valid   (word_valid),
        .word         (word),
        .out_free     (out_free),
        .take         (take),
        .result_valid (result_valid),
        .result       (result)
    );

    // Hold the result for the consumer
    mrfc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (result_valid),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .held     (held)
    );

    assign m_frame_status   = held.frame_status;
    assign m_frame_address  = held.frame_address;
    assign m_func_code      = held.func_code;
    assign m_start_reg      = held.start_reg;
    assign m_register_count = held.register_count;
    assign m_frame_length   = held.frame_length;

endmodule
